/* hw/rtl/ordered_depth_first_walk_assert.svh */
// Assertion macros shared by the ordered depth-first walk RTL.
`ifndef ORDERED_DEPTH_FIRST_WALK_ASSERT_SVH
`define ORDERED_DEPTH_FIRST_WALK_ASSERT_SVH

// Condition a implies condition c at the same clock edge.
`define ODFW_ASSERT_IMPLIES(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Condition a implies condition c at the following clock edge.
`define ODFW_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

/* hw/rtl/odfw_pkg.sv */
// Shared types and constants for the ordered depth-first walk.
package odfw_pkg;

  // Fixed widths of the interface fields.
  localparam int VERTEX_W = 6;
  localparam int CFG_W    = 7;
  localparam int OP_W     = 2;
  localparam int CNT_W    = 6;

  // A walk emits at most this many tree edges.
  localparam int RESULT_CAP = 63;

  // Vertex count after reset.
  localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;

  // Operation codes of an input word.
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_WALK  = 2'd2;

  // Lanes in one group of the lowest-bit search.
  localparam int GROUP_W = 8;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_FETCH,
    ST_MASK,
    ST_SCAN,
    ST_DECIDE,
    ST_POP,
    ST_FINISH
  } state_t;

  // One result word as loaded into the output register.
  typedef struct packed {
    logic [VERTEX_W-1:0] parent;
    logic [VERTEX_W-1:0] child;
    logic                edge_valid;
    logic                bad_start;
    logic                last;
  } out_word_t;

endpackage

/* hw/rtl/ordered_depth_first_walk.sv */
// Ordered depth-first walk: clear is done from idle, add edge passes the add state; a walk
// steps fetch, mask, scan and decide per tree edge, pop on backtrack; no new word meanwhile.
// Each step is one adjacency row read followed by the two-stage lowest-bit search.
// The final word of a walk leaves only once the output register is free.
// Synchronous reset clears the graph through per-row valid bits and sets the vertex
// count to 64; there is no clearing pass, so a word is taken in the first idle cycle.
`include "ordered_depth_first_walk_assert.svh"

module ordered_depth_first_walk #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [odfw_pkg::CFG_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [odfw_pkg::OP_W-1:0]         op,
  input  logic [odfw_pkg::VERTEX_W-1:0]     from_vertex,
  input  logic [odfw_pkg::VERTEX_W-1:0]     to_vertex,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [odfw_pkg::VERTEX_W-1:0]     tree_parent,
  output logic [odfw_pkg::VERTEX_W-1:0]     tree_child,
  output logic                              edge_valid,
  output logic                              bad_start,
  output logic                              last
);

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int LW   = $clog2(MAX_VERTICES + 1);
  localparam int DW   = LW;
  localparam int LIMW = (odfw_pkg::CFG_W > LW) ? odfw_pkg::CFG_W : LW;
  localparam int CMPW = (odfw_pkg::VERTEX_W > LW) ? odfw_pkg::VERTEX_W : LW;
  localparam int CW   = odfw_pkg::CNT_W;

  odfw_pkg::state_t state, state_next;

  logic [odfw_pkg::CFG_W-1:0] vcount;
  logic [LIMW-1:0]            lim_full;
  logic [LW-1:0]              lim;
  logic [MAX_VERTICES-1:0]    limmask;
  logic                       from_ok, to_ok;
  logic [VW-1:0]              from_v, to_v;

  // Adjacency store and its per-row valid bits.
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_ok;
  logic [MAX_VERTICES-1:0] row_q;
  logic                    rowv_q;
  logic [VW-1:0]           adj_raddr;
  logic [MAX_VERTICES-1:0] row_word;
  logic [MAX_VERTICES-1:0] add_word;
  logic [VW-1:0]           add_row, add_col;

  // Walk stack.
  logic [VW-1:0] stack_mem [MAX_VERTICES];
  logic [VW-1:0] stack_q;
  logic          stack_we;
  logic [VW-1:0] stack_waddr, stack_wdata;
  logic [DW-1:0] depth_m2;

  // Walk state.
  logic [MAX_VERTICES-1:0] visited;
  logic [VW-1:0]           top;
  logic [VW-1:0]           start_v;
  logic [DW-1:0]           depth;
  logic [CW-1:0]           count;
  logic                    bad_q;
  logic                    pend_valid;
  logic [VW-1:0]           pend_parent, pend_child;

  // Search unit.
  logic [MAX_VERTICES-1:0] cand;
  logic                    find_hit;
  logic [VW-1:0]           find_idx;

  // Sequencer controls.
  logic                in_accept;
  logic                slot_free;
  logic                push_ok;
  logic                push_go;
  logic                pop_go;
  logic                load_out;
  logic                walk_step;
  odfw_pkg::out_word_t out_word;

  // Effective vertex limit and the mask of vertices below it.
  always_comb begin
    lim_full = (LIMW'(vcount) < LIMW'(MAX_VERTICES)) ? LIMW'(vcount) : LIMW'(MAX_VERTICES);
    lim      = LW'(lim_full);
    for (int i = 0; i < MAX_VERTICES; i++) begin
      limmask[i] = (LW'(i) < lim);
    end
  end

  assign from_ok = CMPW'(from_vertex) < CMPW'(lim);
  assign to_ok   = CMPW'(to_vertex) < CMPW'(lim);
  assign from_v  = VW'(from_vertex);
  assign to_v    = VW'(to_vertex);

  // Candidate neighbours of the top vertex.
  assign row_word = rowv_q ? row_q : '0;
  assign cand     = row_word & ~visited & limmask;
  assign add_word = row_word | (MAX_VERTICES'(1) << add_col);

  odfw_find #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_find (
    .clk  (clk),
    .cand (cand),
    .hit  (find_hit),
    .idx  (find_idx)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      odfw_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (op)
            odfw_pkg::OP_ADD: begin
              if (from_ok && to_ok) begin
                state_next = odfw_pkg::ST_ADD;
              end
            end
            odfw_pkg::OP_WALK: begin
              state_next = from_ok ? odfw_pkg::ST_FETCH : odfw_pkg::ST_FINISH;
            end
            default: begin
              state_next = odfw_pkg::ST_IDLE;
            end
          endcase
        end
      end
      odfw_pkg::ST_ADD:   state_next = odfw_pkg::ST_IDLE;
      odfw_pkg::ST_FETCH: state_next = odfw_pkg::ST_MASK;
      odfw_pkg::ST_MASK:  state_next = odfw_pkg::ST_SCAN;
      odfw_pkg::ST_SCAN:  state_next = odfw_pkg::ST_DECIDE;
      odfw_pkg::ST_DECIDE: begin
        if (push_ok) begin
          if (push_go) begin
            state_next = odfw_pkg::ST_FETCH;
          end
        end else if (depth == DW'(1)) begin
          state_next = odfw_pkg::ST_FINISH;
        end else begin
          state_next = odfw_pkg::ST_POP;
        end
      end
      odfw_pkg::ST_POP: state_next = odfw_pkg::ST_FETCH;
      odfw_pkg::ST_FINISH: begin
        if (slot_free) begin
          state_next = odfw_pkg::ST_IDLE;
        end
      end
      default: state_next = odfw_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = (state != odfw_pkg::ST_IDLE);
    in_accept = in_valid && (state == odfw_pkg::ST_IDLE);
    slot_free = !out_valid || !out_stall;
    push_ok   = find_hit && (depth < DW'(MAX_VERTICES)) && (count < CW'(odfw_pkg::RESULT_CAP));
    push_go   = (state == odfw_pkg::ST_DECIDE) && push_ok && (!pend_valid || slot_free);
    pop_go    = (state == odfw_pkg::ST_DECIDE) && !push_ok;
    adj_raddr = (state == odfw_pkg::ST_IDLE) ? from_v : top;
    depth_m2  = depth - DW'(2);

    stack_we    = 1'b0;
    stack_waddr = depth[VW-1:0];
    stack_wdata = find_idx;
    if (in_accept && (op == odfw_pkg::OP_WALK) && from_ok) begin
      stack_we    = 1'b1;
      stack_waddr = '0;
      stack_wdata = from_v;
    end else if (push_go) begin
      stack_we = 1'b1;
    end

    load_out = 1'b0;
    out_word = '0;
    if (push_go && pend_valid) begin
      // The previous edge is now known not to be the last.
      load_out            = 1'b1;
      out_word.parent     = odfw_pkg::VERTEX_W'(pend_parent);
      out_word.child      = odfw_pkg::VERTEX_W'(pend_child);
      out_word.edge_valid = 1'b1;
    end else if ((state == odfw_pkg::ST_FINISH) && slot_free) begin
      load_out      = 1'b1;
      out_word.last = 1'b1;
      if (bad_q) begin
        out_word.bad_start = 1'b1;
      end else if (pend_valid) begin
        out_word.parent     = odfw_pkg::VERTEX_W'(pend_parent);
        out_word.child      = odfw_pkg::VERTEX_W'(pend_child);
        out_word.edge_valid = 1'b1;
      end else begin
        out_word.parent = odfw_pkg::VERTEX_W'(start_v);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= odfw_pkg::ST_IDLE;
      vcount     <= odfw_pkg::VCOUNT_RESET;
      row_ok     <= '0;
      visited    <= '0;
      depth      <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        vcount <= cfg_wr_data;
      end
      if (in_accept && (op == odfw_pkg::OP_CLEAR)) begin
        row_ok <= '0;
      end
      if (state == odfw_pkg::ST_ADD) begin
        row_ok[add_row] <= 1'b1;
      end
      if (in_accept && (op == odfw_pkg::OP_WALK)) begin
        pend_valid <= 1'b0;
        if (from_ok) begin
          visited <= MAX_VERTICES'(1) << from_v;
          depth   <= DW'(1);
          count   <= '0;
        end
      end
      if (push_go) begin
        visited[find_idx] <= 1'b1;
        depth             <= depth + DW'(1);
        count             <= count + CW'(1);
        pend_valid        <= 1'b1;
      end
      if (pop_go) begin
        depth <= depth - DW'(1);
      end
      if ((state == odfw_pkg::ST_FINISH) && slot_free) begin
        pend_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rowv_q <= row_ok[adj_raddr];
    if (in_accept) begin
      add_row <= from_v;
      add_col <= to_v;
      if (op == odfw_pkg::OP_WALK) begin
        bad_q   <= !from_ok;
        top     <= from_v;
        start_v <= from_v;
      end
    end
    if (push_go) begin
      top         <= find_idx;
      pend_parent <= top;
      pend_child  <= find_idx;
    end
    if (state == odfw_pkg::ST_POP) begin
      top <= stack_q;
    end
    if (load_out) begin
      tree_parent <= out_word.parent;
      tree_child  <= out_word.child;
      edge_valid  <= out_word.edge_valid;
      bad_start   <= out_word.bad_start;
      last        <= out_word.last;
    end
  end

  // Adjacency memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (state == odfw_pkg::ST_ADD) begin
      adj_mem[add_row] <= add_word;
    end
    row_q <= adj_mem[adj_raddr];
  end

  // Stack memory: the read fetches the entry below the top for a pop.
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    stack_q <= stack_mem[depth_m2[VW-1:0]];
  end

  // A walk step is in progress while a row is fetched or a decision is taken.
  assign walk_step = (state == odfw_pkg::ST_FETCH) || (state == odfw_pkg::ST_DECIDE);

  // Checks on the sequencer.
  `ODFW_ASSERT_IMPLIES(a_top_visited, state == odfw_pkg::ST_FETCH, visited[top], "top not visited")
  `ODFW_ASSERT_IMPLIES(a_walk_depth, walk_step, depth != DW'(0), "walk step with empty stack")
  `ODFW_ASSERT_IMPLIES(a_pend_count, pend_valid, count != CW'(0), "pending edge without a count")
  `ODFW_ASSERT_NEXT(a_push_depth, push_go, depth == $past(depth) + DW'(1), "stack did not grow")

endmodule

/* hw/rtl/odfw_find.sv */
// Two-stage registered search for the lowest set bit of a candidate vector.
module odfw_find #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                            clk,
  input  logic [MAX_VERTICES-1:0]         cand,
  output logic                            hit,
  output logic [$clog2(MAX_VERTICES)-1:0] idx
);

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int GRP   = odfw_pkg::GROUP_W;
  localparam int NG    = (MAX_VERTICES + GRP - 1) / GRP;
  localparam int PADW  = NG * GRP;
  localparam int GW    = (NG > 1) ? $clog2(NG) : 1;
  localparam int LOW_W = $clog2(GRP);

  logic [PADW-1:0]  cand_pad;
  logic [NG-1:0]    grp_any_c;
  logic [LOW_W-1:0] grp_low_c [NG];
  logic [NG-1:0]    grp_any;
  logic [LOW_W-1:0] grp_low [NG];
  logic             hit_c;
  logic [GW+LOW_W-1:0] sel_c;

  assign cand_pad = PADW'(cand);

  // First stage: per group, whether any bit is set and the lowest one.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_c[g] = |cand_pad[g*GRP +: GRP];
      grp_low_c[g] = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
        if (cand_pad[g*GRP + b]) begin
          grp_low_c[g] = LOW_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any <= grp_any_c;
    grp_low <= grp_low_c;
  end

  // Second stage: the lowest group with a set bit gives the index.
  always_comb begin
    hit_c = 1'b0;
    sel_c = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        hit_c = 1'b1;
        sel_c = {GW'(g), grp_low[g]};
      end
    end
  end

  always_ff @(posedge clk) begin
    hit <= hit_c;
    idx <= VW'(sel_c);
  end

endmodule

/* verif/ordered_depth_first_walk_checker.sv */
// Checker for the ordered depth-first walk: predicts the result words and compares them.
module ordered_depth_first_walk_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [odfw_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [odfw_pkg::OP_W-1:0]     op,
  input  logic [odfw_pkg::VERTEX_W-1:0] from_vertex,
  input  logic [odfw_pkg::VERTEX_W-1:0] to_vertex,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [odfw_pkg::VERTEX_W-1:0] tree_parent,
  input  logic [odfw_pkg::VERTEX_W-1:0] tree_child,
  input  logic                          edge_valid,
  input  logic                          bad_start,
  input  logic                          last,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 64;

  // Shadow copy of the graph and of the vertex count register.
  logic [NV-1:0]              edge_rows [NV];
  logic [odfw_pkg::CFG_W-1:0] vertex_count_q;
  odfw_pkg::out_word_t        walk_edges_q [$];

  // The count in force, capped at the size of the matrix.
  function automatic int vertex_limit();
    return (vertex_count_q > NV) ? NV : int'(vertex_count_q);
  endfunction

  // Depth-first walk that always takes the lowest unvisited neighbour;
  // the top of the path is dropped once it has no such neighbour, the path is full or the edge cap is reached.
  task automatic predict_walk(input logic [odfw_pkg::VERTEX_W-1:0] start);
    int                            lim;
    int                            depth;
    int                            found;
    int                            n;
    logic [NV-1:0]                 seen;
    logic [odfw_pkg::VERTEX_W-1:0] path [NV];
    odfw_pkg::out_word_t           w;
    odfw_pkg::out_word_t           tree [$];
    lim = vertex_limit();
    w = '0;
    if (start >= lim) begin
      w.bad_start = 1'b1;
      w.last = 1'b1;
      walk_edges_q = {walk_edges_q, w};
      return;
    end
    seen = '0;
    seen[start] = 1'b1;
    path[0] = start;
    depth = 1;
    while (depth > 0) begin
      found = -1;
      for (n = 0; n < lim && found < 0; n++) begin
        if (edge_rows[path[depth-1]][n] && !seen[n]) found = n;
      end
      if (found >= 0 && depth < NV && tree.size() < odfw_pkg::RESULT_CAP) begin
        w = '0;
        w.parent = path[depth-1];
        w.child = odfw_pkg::VERTEX_W'(found);
        w.edge_valid = 1'b1;
        tree = {tree, w};
        seen[found] = 1'b1;
        path[depth] = odfw_pkg::VERTEX_W'(found);
        depth++;
      end else begin
        depth--;
      end
    end
    // A walk that found no tree edge still answers with one word.
    if (tree.size() == 0) begin
      w = '0;
      w.parent = start;
      w.last = 1'b1;
      walk_edges_q = {walk_edges_q, w};
    end else begin
      tree[tree.size()-1].last = 1'b1;
      walk_edges_q = {walk_edges_q, tree};
    end
  endtask

  // Update the shadow state for one accepted input word.
  task automatic apply_word(input logic [odfw_pkg::OP_W-1:0] w_op,
                            input logic [odfw_pkg::VERTEX_W-1:0] a,
                            input logic [odfw_pkg::VERTEX_W-1:0] b);
    int lim;
    lim = vertex_limit();
    case (w_op)
      odfw_pkg::OP_CLEAR: begin
        foreach (edge_rows[i]) edge_rows[i] = '0;
      end
      odfw_pkg::OP_ADD: begin
        if (a < lim && b < lim) edge_rows[a][b] = 1'b1;
      end
      odfw_pkg::OP_WALK: begin
        predict_walk(a);
      end
      default: begin
      end
    endcase
  endtask

  function automatic int field_differs(input string field,
                                       input logic [odfw_pkg::VERTEX_W-1:0] want,
                                       input logic [odfw_pkg::VERTEX_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Compare one accepted result word with the oldest expectation.
  task automatic check_word();
    odfw_pkg::out_word_t want;
    int                  wrong;
    if (walk_edges_q.size() == 0) begin
      $error("result word with none expected: parent %0d child %0d valid %0b bad %0b last %0b",
             tree_parent, tree_child, edge_valid, bad_start, last);
      fail_count++;
      return;
    end
    want = walk_edges_q.pop_front();
    wrong = field_differs("tree_parent", want.parent, tree_parent)
          + field_differs("tree_child", want.child, tree_child)
          + field_differs("edge_valid", want.edge_valid, edge_valid)
          + field_differs("bad_start", want.bad_start, bad_start)
          + field_differs("last", want.last, last);
    if (wrong != 0) fail_count++;
  endtask

  // Results are retired before new words are predicted at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      foreach (edge_rows[i]) edge_rows[i] = '0;
      vertex_count_q = odfw_pkg::VCOUNT_RESET;
      walk_edges_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) check_word();
      if (cfg_wr_en) vertex_count_q = cfg_wr_data;
      if (in_valid && !in_stall) apply_word(op, from_vertex, to_vertex);
    end
    pending = walk_edges_q.size();
  end

endmodule

/* verif/ordered_depth_first_walk_tb.sv */
// Testbench top for the ordered depth-first walk: stimulus, output stalls and verdict.
module ordered_depth_first_walk_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [odfw_pkg::OP_W-1:0] OP_NONE = 2'd3;
  localparam int RANDOM_WORDS  = 380;
  localparam int PHASE_WORDS   = 35;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 50000;
  localparam int TIMEOUT_NS    = 40_000_000;

  logic                          clk;
  logic                          rst;
  logic                          cfg_wr_en;
  logic [odfw_pkg::CFG_W-1:0]    cfg_wr_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [odfw_pkg::OP_W-1:0]     op;
  logic [odfw_pkg::VERTEX_W-1:0] from_vertex;
  logic [odfw_pkg::VERTEX_W-1:0] to_vertex;
  logic                          out_valid;
  logic                          out_stall;
  logic [odfw_pkg::VERTEX_W-1:0] tree_parent;
  logic [odfw_pkg::VERTEX_W-1:0] tree_child;
  logic                          edge_valid;
  logic                          bad_start;
  logic                          last;
  int                            fail_count;
  int                            results_owed;
  int                            words_sent;
  int                            cur_limit;

  // Vertex count settings visited by the random part, extremes first.
  int count_plan [12] = '{1, 64, 0, 127, 2, 17, 5, 40, 3, 9, 64, 11};

  ordered_depth_first_walk u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .from_vertex (from_vertex),
    .to_vertex   (to_vertex),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tree_parent (tree_parent),
    .tree_child  (tree_child),
    .edge_valid  (edge_valid),
    .bad_start   (bad_start),
    .last        (last)
  );

  ordered_depth_first_walk_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .from_vertex (from_vertex),
    .to_vertex   (to_vertex),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tree_parent (tree_parent),
    .tree_child  (tree_child),
    .edge_valid  (edge_valid),
    .bad_start   (bad_start),
    .last        (last),
    .fail_count  (fail_count),
    .pending     (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [odfw_pkg::VERTEX_W-1:0] any_vertex();
    return odfw_pkg::VERTEX_W'($urandom_range(0, 63));
  endfunction

  // A vertex below the limit, or any vertex when none is in use.
  function automatic logic [odfw_pkg::VERTEX_W-1:0] pick_vertex(input int lim);
    if (lim <= 0) return any_vertex();
    return odfw_pkg::VERTEX_W'($urandom_range(0, lim - 1));
  endfunction

  // Output side: stall stretches between free stretches, some of them long.
  initial begin
    int free_run;
    forever begin
      out_stall = 1'b0;
      free_run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      repeat (free_run) @(negedge clk);
      out_stall = 1'b1;
      repeat (idle_len() + 1) @(negedge clk);
    end
  end

  // Offer one input word from a falling edge and hold it until it is taken.
  task automatic send_word(input logic [odfw_pkg::OP_W-1:0] w_op,
                           input logic [odfw_pkg::VERTEX_W-1:0] a,
                           input logic [odfw_pkg::VERTEX_W-1:0] b);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    op = w_op;
    from_vertex = a;
    to_vertex = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Write the vertex count once every owed result has left and the block has settled.
  task automatic set_vertex_count(input int count);
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = odfw_pkg::CFG_W'(count);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cur_limit = (count > 64) ? 64 : count;
  endtask

  // One round: an optional clear, a graph build of some shape, then walks.
  task automatic run_round(input int lim);
    int                            shape;
    int                            span;
    int                            len;
    int                            j;
    int                            k;
    logic [odfw_pkg::VERTEX_W-1:0] order [64];
    logic [odfw_pkg::VERTEX_W-1:0] tmp;
    logic [odfw_pkg::VERTEX_W-1:0] chain_head;
    chain_head = pick_vertex(lim);
    if ($urandom_range(0, 2) == 0) send_word(odfw_pkg::OP_CLEAR, any_vertex(), any_vertex());
    shape = $urandom_range(0, 9);
    if (shape <= 5) begin
      // Scattered edges, a few of them out of range.
      k = $urandom_range(1, (lim > 10) ? 24 : 2 * lim + 1);
      repeat (k) begin
        if ($urandom_range(0, 9) == 0) send_word(odfw_pkg::OP_ADD, any_vertex(), any_vertex());
        else send_word(odfw_pkg::OP_ADD, pick_vertex(lim), pick_vertex(lim));
      end
    end else if (shape <= 7 && lim >= 2) begin
      // A path through shuffled vertices, often all of them.
      for (j = 0; j < lim; j++) order[j] = odfw_pkg::VERTEX_W'(j);
      for (j = lim - 1; j > 0; j--) begin
        k = $urandom_range(0, j);
        tmp = order[j];
        order[j] = order[k];
        order[k] = tmp;
      end
      span = (lim <= 16 || $urandom_range(0, 1) == 1) ? lim : $urandom_range(2, lim);
      for (len = 0; len < span - 1; len++) begin
        send_word(odfw_pkg::OP_ADD, order[len], order[len + 1]);
      end
      chain_head = order[0];
      send_word(odfw_pkg::OP_WALK, chain_head, any_vertex());
    end else if (shape == 8) begin
      // Noise: any operation code with any fields.
      repeat ($urandom_range(1, 6)) begin
        send_word(odfw_pkg::OP_W'($urandom_range(0, 3)), any_vertex(), any_vertex());
      end
    end
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 5) == 0) send_word(odfw_pkg::OP_WALK, any_vertex(), any_vertex());
      else send_word(odfw_pkg::OP_WALK, pick_vertex(lim), any_vertex());
    end
  endtask

  initial begin
    int phase;
    int phase_begin;
    int random_begin;
    int j;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    op = odfw_pkg::OP_CLEAR;
    from_vertex = '0;
    to_vertex = '0;
    words_sent = 0;
    cur_limit = 64;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the reset count: empty walks at both ends of the range.
    send_word(odfw_pkg::OP_WALK, 6'd0, 6'd63);
    send_word(odfw_pkg::OP_WALK, 6'd63, 6'd0);
    // Small graph with a self loop and edges back to visited vertices.
    send_word(odfw_pkg::OP_ADD, 6'd0, 6'd63);
    send_word(odfw_pkg::OP_ADD, 6'd63, 6'd63);
    send_word(odfw_pkg::OP_ADD, 6'd63, 6'd0);
    send_word(odfw_pkg::OP_ADD, 6'd0, 6'd5);
    send_word(odfw_pkg::OP_ADD, 6'd5, 6'd7);
    send_word(odfw_pkg::OP_ADD, 6'd7, 6'd5);
    send_word(OP_NONE, 6'd63, 6'd63);
    send_word(odfw_pkg::OP_WALK, 6'd0, 6'd0);
    send_word(odfw_pkg::OP_WALK, 6'd63, 6'd0);
    send_word(odfw_pkg::OP_WALK, 6'd7, 6'd0);
    send_word(odfw_pkg::OP_ADD, 6'd2, 6'd40);
    send_word(odfw_pkg::OP_CLEAR, 6'd63, 6'd63);
    send_word(odfw_pkg::OP_ADD, 6'd2, 6'd40);

    // Small count: out-of-range edges, a neighbour beyond the limit, bad starts.
    set_vertex_count(4);
    send_word(odfw_pkg::OP_ADD, 6'd4, 6'd1);
    send_word(odfw_pkg::OP_ADD, 6'd1, 6'd9);
    send_word(odfw_pkg::OP_ADD, 6'd0, 6'd1);
    send_word(odfw_pkg::OP_WALK, 6'd2, 6'd0);
    send_word(odfw_pkg::OP_WALK, 6'd0, 6'd0);
    send_word(odfw_pkg::OP_WALK, 6'd4, 6'd0);
    send_word(odfw_pkg::OP_WALK, 6'd63, 6'd0);

    // Random part: rounds of graph building and walking under each count setting.
    random_begin = words_sent;
    phase = 0;
    while (words_sent - random_begin < RANDOM_WORDS) begin
      set_vertex_count(count_plan[phase % 12]);
      phase_begin = words_sent;
      while (words_sent - phase_begin < PHASE_WORDS &&
             words_sent - random_begin < RANDOM_WORDS) begin
        run_round(cur_limit);
      end
      phase++;
    end

    // Let every owed result arrive, then give the verdict.
    in_valid = 1'b0;
    for (j = 0; j < DRAIN_CYCLES && results_owed != 0; j++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (results_owed != 0) $error("%0d result words never arrived", results_owed);
    if (fail_count == 0 && results_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/odfw_pkg.sv
hw/rtl/odfw_find.sv
hw/rtl/ordered_depth_first_walk.sv
verif/ordered_depth_first_walk_checker.sv
verif/ordered_depth_first_walk_tb.sv
